// ===== design/ffba_pkg.sv =====
// Package with shared types, constants and codes for the first-fit block allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;
  localparam int MaxBlocks = 32;
  localparam int AddrBits  = 20;
  localparam int IdxBits   = $clog2(MaxBlocks);
  localparam int CntBits   = $clog2(MaxBlocks + 1);
  localparam int SizeBits  = 20;
  localparam int HdrBits   = 7;
  localparam int LimBits   = 21;

  localparam logic [1:0] ST_OK             = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND      = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL     = 2'd2;
  localparam logic [1:0] ST_HEAP_EXHAUSTED = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic CFG_HEADER = 1'b0;
  localparam logic CFG_LIMIT  = 1'b1;

  typedef struct packed {
    logic [AddrBits-1:0] start;
    logic [SizeBits-1:0] size;
    logic                free;
  } entry_t;

  // Command broadcast to every cell in the same cycle.
  typedef struct packed {
    logic               hit;
    logic [IdxBits-1:0] pos;
    logic               split;
    logic               shift;
    logic               take;
    logic               release_blk;
    logic               append;
    logic [IdxBits-1:0] app_pos;
    entry_t             new_ent;
    logic [SizeBits-1:0] cut_size;
    entry_t             rem_ent;
  } cell_cmd_t;
endpackage
`default_nettype wire

// ===== design/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator with a chain of table cells.
//
// Requests enter on in_valid/in_ready with in_req_type, in_req_size and
// in_req_addr. An allocate scans the entry cells one per cycle for the first
// free block that fits, splitting it when a header fits in the remainder and
// the table has room; if none fits it grows the heap top when the table and limit allow. A free
// scans for a matching payload offset. Each request yields one result on
// out_valid/out_ready. A request that hits an entry shows its result once
// the scan reaches that entry. A request that finds nothing scans every
// entry and then passes S_DONE, where its result is decided.
// One request is handled at a time, and the next one is accepted the cycle
// after the result is taken. A split writes the remainder into the next
// cell and shifts all cells after it one place to the right in the same
// cycle, each cell loading its left neighbor. While a result waits for
// out_ready the block holds it and accepts no new request. Configuration
// writes on cfg_valid/cfg_ready are always taken; index 0 is header_bytes,
// index 1 is heap_limit. Reset clears the entry count, heap top and the
// control state; entry contents are undefined until written. Reset values:
// header 25, limit 2^20.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_block_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_req_type,
  input  wire logic [19:0] in_req_size,
  input  wire logic [19:0] in_req_addr,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [19:0]      out_grant_addr,
  output logic [5:0]       out_blocks_in_use,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [20:0] cfg_data
);
  localparam int IB = ffba_pkg::IdxBits;
  localparam int CB = ffba_pkg::CntBits;
  localparam int AB = ffba_pkg::AddrBits;
  localparam int SB = ffba_pkg::SizeBits;
  localparam int LB = ffba_pkg::LimBits;
  localparam int HB = ffba_pkg::HdrBits;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;
  localparam logic [AB:0] AMask = (AB+1)'((64'd1 << AB) - 64'd1);

  logic [1:0]    state_r, state_nxt;
  logic [HB-1:0] hdr_r;
  logic [LB-1:0] lim_r;
  logic [CB-1:0] cnt_r, cnt_nxt;
  logic [LB-1:0] top_r, top_nxt;
  logic          typ_r;
  logic [SB-1:0] size_r;
  logic [AB-1:0] addr_r;
  logic [CB-1:0] scan_r, scan_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [AB-1:0] grant_r, grant_nxt;

  ffba_pkg::cell_cmd_t cmd;
  ffba_pkg::entry_t    ents [ffba_pkg::MaxBlocks];
  ffba_pkg::entry_t    cur;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign cfg_ready = 1'b1;
  assign out_status = st_r;
  assign out_grant_addr = grant_r;
  assign out_blocks_in_use = 6'(cnt_r);

  genvar g;
  generate
    for (g = 0; g < ffba_pkg::MaxBlocks; g++) begin : g_cell
      ffba_cell u_cell (
        .clk      (clk),
        .my_idx   (IB'(g)),
        .left_ent ((g == 0) ? ents[0] : ents[(g == 0) ? 0 : g-1]),
        .cmd      (cmd),
        .ent      (ents[g])
      );
    end
  endgenerate

  logic [IB-1:0] sidx;
  logic [SB+HB:0] need;
  logic [AB:0]    pay;
  logic [LB+1:0]  endv;
  logic [LB-1:0]  lim_eff;
  logic           in_range;

  always_comb begin
    sidx = scan_r[IB-1:0];
    cur  = ents[sidx];
    need = (SB+HB+1)'(size_r) + (SB+HB+1)'(hdr_r);
    pay  = (AB+1)'(cur.start) + (AB+1)'(hdr_r);
    endv = (LB+2)'(top_r) + (LB+2)'(hdr_r) + (LB+2)'(size_r);
    lim_eff = (lim_r > LB'(AMask)) ? LB'(AMask) : lim_r;
    in_range = scan_r < cnt_r;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    top_nxt   = top_r;
    scan_nxt  = scan_r;
    st_nxt    = st_r;
    grant_nxt = grant_r;
    cmd       = '0;
    cmd.pos   = sidx;
    cmd.app_pos = cnt_r[IB-1:0];
    cmd.cut_size = size_r;
    cmd.rem_ent.start = AB'(cur.start + AB'(hdr_r) + AB'(size_r));
    cmd.rem_ent.size  = SB'((SB+HB+1)'(cur.size) - need);
    cmd.rem_ent.free  = 1'b1;
    cmd.new_ent.start = AB'(top_r);
    cmd.new_ent.size  = size_r;
    cmd.new_ent.free  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
          scan_nxt  = '0;
        end
      end
      S_SCAN: begin
        if (!in_range) begin
          state_nxt = S_DONE;
        end else if (typ_r == ffba_pkg::REQ_FREE) begin
          if (pay[AB-1:0] == addr_r && !pay[AB]) begin
            cmd.hit = 1'b1;
            cmd.release_blk = 1'b1;
            st_nxt = ffba_pkg::ST_OK;
            grant_nxt = '0;
            state_nxt = S_OUT;
          end else begin
            scan_nxt = scan_r + 1'b1;
          end
        end else if (cur.free && (SB+HB+1)'(cur.size) >= (SB+HB+1)'(size_r)) begin
          cmd.hit  = 1'b1;
          cmd.take = 1'b1;
          if ((SB+HB+1)'(cur.size) >= need && cnt_r < CB'(ffba_pkg::MaxBlocks)) begin
            cmd.split = 1'b1;
            cmd.shift = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
          st_nxt = ffba_pkg::ST_OK;
          grant_nxt = pay[AB-1:0];
          state_nxt = S_OUT;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_DONE: begin
        grant_nxt = '0;
        state_nxt = S_OUT;
        if (typ_r == ffba_pkg::REQ_FREE) begin
          st_nxt = ffba_pkg::ST_NOT_FOUND;
        end else if (cnt_r >= CB'(ffba_pkg::MaxBlocks)) begin
          st_nxt = ffba_pkg::ST_TABLE_FULL;
        end else if (endv > (LB+2)'(lim_eff)) begin
          st_nxt = ffba_pkg::ST_HEAP_EXHAUSTED;
        end else begin
          cmd.append = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          top_nxt = LB'(endv);
          st_nxt = ffba_pkg::ST_OK;
          grant_nxt = AB'((LB+2)'(top_r) + (LB+2)'(hdr_r));
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      top_r   <= '0;
      hdr_r   <= HB'(25);
      lim_r   <= LB'(1048576);
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      top_r   <= top_nxt;
      if (cfg_valid && cfg_index == ffba_pkg::CFG_HEADER) begin
        hdr_r <= cfg_data[HB-1:0];
      end
      if (cfg_valid && cfg_index == ffba_pkg::CFG_LIMIT) begin
        lim_r <= cfg_data[LB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_r  <= scan_nxt;
    st_r    <= st_nxt;
    grant_r <= grant_nxt;
    if (in_valid && in_ready) begin
      typ_r  <= in_req_type;
      size_r <= in_req_size;
      addr_r <= in_req_addr;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CB'(ffba_pkg::MaxBlocks)) else $error("entry count overflow");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != $past(cnt_r) |-> cnt_r == $past(cnt_r) + 1'b1)
    else $error("entry count changed by more than one");
  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ffba_pkg::ST_OK |-> out_grant_addr == '0)
    else $error("grant not zero on failure");
endmodule
`default_nettype wire

// ===== design/ffba_cell.sv =====
// One table cell: holds an entry, can load from its left neighbor for an insert shift.
`timescale 1ns / 1ps
`default_nettype none
module ffba_cell (
  input  wire logic                       clk,
  input  wire logic [ffba_pkg::IdxBits-1:0] my_idx,
  input  wire ffba_pkg::entry_t           left_ent,
  input  wire ffba_pkg::cell_cmd_t        cmd,
  output ffba_pkg::entry_t                ent
);
  ffba_pkg::entry_t ent_r;
  ffba_pkg::entry_t ent_nxt;

  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.append && cmd.app_pos == my_idx) begin
      ent_nxt = cmd.new_ent;
    end else if (cmd.hit && cmd.pos == my_idx) begin
      if (cmd.take) begin
        ent_nxt.free = 1'b0;
        if (cmd.split) begin
          ent_nxt.size = cmd.cut_size;
        end
      end
      if (cmd.release_blk) begin
        ent_nxt.free = 1'b1;
      end
    end else if (cmd.split && my_idx == cmd.pos + 1'b1) begin
      ent_nxt = cmd.rem_ent;
    end else if (cmd.split && cmd.shift && my_idx > cmd.pos + 1'b1) begin
      ent_nxt = left_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end
endmodule
`default_nettype wire

// ===== test/first_fit_block_allocator_test.sv =====
// Self-checking testbench for the first-fit block allocator with a built-in allocation predictor.
`timescale 1ns / 1ps
module first_fit_block_allocator_test;

  typedef struct {
    logic        kind;
    logic [19:0] size;
    logic [19:0] addr;
  } heap_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [19:0] grant;
    logic [5:0]  in_use;
  } heap_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = 1'b0;
  logic [19:0] in_req_size = '0;
  logic [19:0] in_req_addr = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [19:0] out_grant_addr;
  logic [5:0]  out_blocks_in_use;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [20:0] cfg_data = '0;

  first_fit_block_allocator uut (.*);

  always #1 clk = ~clk;

  heap_req_t  pending_reqs[$];
  heap_resp_t expected_resps[$];
  logic [19:0] live_grants[$];
  heap_req_t  cur_req;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int pushed_total = 0;
  int checked_total = 0;

  logic [19:0] blk_start[ffba_pkg::MaxBlocks];
  logic [19:0] blk_size[ffba_pkg::MaxBlocks];
  logic        blk_free[ffba_pkg::MaxBlocks];
  int          blk_count = 0;
  logic [20:0] heap_top = '0;
  logic [6:0]  hdr_cfg = 7'd25;
  logic [20:0] limit_cfg = 21'd1048576;

  function automatic heap_resp_t allocate_block(logic [19:0] size);
    heap_resp_t r;
    logic [21:0] lim;
    logic [21:0] top_end;
    r.status = ffba_pkg::ST_OK;
    r.grant = '0;
    for (int i = 0; i < blk_count; i++) begin
      if (blk_free[i] && 22'(blk_size[i]) >= 22'(size) + 22'(hdr_cfg)) begin
        if (blk_count < ffba_pkg::MaxBlocks) begin
          for (int k = blk_count; k > i + 1; k--) begin
            blk_start[k] = blk_start[k-1];
            blk_size[k] = blk_size[k-1];
            blk_free[k] = blk_free[k-1];
          end
          blk_start[i+1] = 20'(blk_start[i] + hdr_cfg + size);
          blk_size[i+1] = 20'(blk_size[i] - size - hdr_cfg);
          blk_free[i+1] = 1'b1;
          blk_count++;
          blk_size[i] = size;
        end
        blk_free[i] = 1'b0;
        r.grant = 20'(blk_start[i] + hdr_cfg);
        return r;
      end
      if (blk_free[i] && blk_size[i] >= size) begin
        blk_free[i] = 1'b0;
        r.grant = 20'(blk_start[i] + hdr_cfg);
        return r;
      end
    end
    if (blk_count >= ffba_pkg::MaxBlocks) begin
      r.status = ffba_pkg::ST_TABLE_FULL;
      return r;
    end
    lim = (limit_cfg > 21'hFFFFF) ? 22'hFFFFF : 22'(limit_cfg);
    top_end = 22'(heap_top) + 22'(hdr_cfg) + 22'(size);
    if (top_end > lim) begin
      r.status = ffba_pkg::ST_HEAP_EXHAUSTED;
      return r;
    end
    blk_start[blk_count] = heap_top[19:0];
    blk_size[blk_count] = size;
    blk_free[blk_count] = 1'b0;
    blk_count++;
    r.grant = 20'(heap_top + hdr_cfg);
    heap_top = top_end[20:0];
    return r;
  endfunction

  function automatic heap_resp_t release_block(logic [19:0] addr);
    heap_resp_t r;
    r.status = ffba_pkg::ST_NOT_FOUND;
    r.grant = '0;
    for (int i = 0; i < blk_count; i++) begin
      if (21'(blk_start[i]) + 21'(hdr_cfg) == 21'(addr)) begin
        blk_free[i] = 1'b1;
        r.status = ffba_pkg::ST_OK;
        break;
      end
    end
    return r;
  endfunction

  task automatic predict_request(heap_req_t q);
    heap_resp_t r;
    if (q.kind == ffba_pkg::REQ_ALLOC) begin
      r = allocate_block(q.size);
      if (r.status == ffba_pkg::ST_OK) begin
        live_grants.push_back(r.grant);
        if (live_grants.size() > 64) void'(live_grants.pop_front());
      end
    end else begin
      r = release_block(q.addr);
    end
    r.in_use = 6'(blk_count);
    expected_resps.push_back(r);
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk) begin
    logic busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        predict_request(cur_req);
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_req_type <= cur_req.kind;
          in_req_size <= cur_req.size;
          in_req_addr <= cur_req.addr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    heap_resp_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        checked_total <= checked_total + 1;
        if (expected_resps.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          e = expected_resps.pop_front();
          if (out_status !== e.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, e.status));
          if (out_grant_addr !== e.grant)
            report_mismatch($sformatf("grant %h, expected %h", out_grant_addr, e.grant));
          if (out_blocks_in_use !== e.in_use)
            report_mismatch($sformatf("in use %0d, expected %0d",
                                      out_blocks_in_use, e.in_use));
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 20000) begin
      $display("FAIL first_fit_block_allocator");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic idx, logic [20:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == ffba_pkg::CFG_HEADER) hdr_cfg = value[6:0];
    else limit_cfg = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic push_req(logic kind, logic [19:0] size, logic [19:0] addr);
    heap_req_t q;
    q.kind = kind;
    q.size = size;
    q.addr = addr;
    pending_reqs.push_back(q);
    pushed_total++;
  endtask

  task automatic drain;
    while (checked_total < pushed_total)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic random_batch(int n);
    int pick;
    logic [19:0] sz;
    logic [19:0] ad;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        pick = $urandom_range(99);
        if (pick < 60) sz = 20'($urandom_range(0, 64));
        else if (pick < 92) sz = 20'($urandom_range(0, 4000));
        else sz = 20'($urandom);
        push_req(ffba_pkg::REQ_ALLOC, sz, 20'($urandom));
      end else begin
        pick = $urandom_range(99);
        if (pick < 75 && live_grants.size() > 0)
          ad = live_grants[$urandom_range(live_grants.size() - 1)];
        else if (pick < 88 && live_grants.size() > 0)
          ad = 20'(live_grants[$urandom_range(live_grants.size() - 1)] +
                   20'($urandom_range(1, 3)));
        else
          ad = 20'($urandom);
        push_req(ffba_pkg::REQ_FREE, 20'($urandom), ad);
      end
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_req(ffba_pkg::REQ_ALLOC, 20'd0, 20'hFFFFF);
    push_req(ffba_pkg::REQ_ALLOC, 20'hFFFFF, 20'd0);
    push_req(ffba_pkg::REQ_FREE, 20'hFFFFF, 20'd0);
    push_req(ffba_pkg::REQ_FREE, 20'd0, 20'hFFFFF);
    push_req(ffba_pkg::REQ_ALLOC, 20'd100, 20'd0);
    push_req(ffba_pkg::REQ_FREE, 20'd0, 20'd75);
    push_req(ffba_pkg::REQ_FREE, 20'd0, 20'd75);
    push_req(ffba_pkg::REQ_ALLOC, 20'd50, 20'd0);
    push_req(ffba_pkg::REQ_ALLOC, 20'd25, 20'd0);
    push_req(ffba_pkg::REQ_FREE, 20'd0, 20'd25);
    push_req(ffba_pkg::REQ_FREE, 20'd0, 20'd26);
    push_req(ffba_pkg::REQ_ALLOC, 20'd0, 20'd0);
    push_req(ffba_pkg::REQ_ALLOC, 20'd7, 20'd0);
    drain();
    write_reg(ffba_pkg::CFG_HEADER, 21'd1);
    push_req(ffba_pkg::REQ_FREE, 20'd0, 20'd25);
    push_req(ffba_pkg::REQ_FREE, 20'd0, 20'd1);
    push_req(ffba_pkg::REQ_ALLOC, 20'd10, 20'd0);
    drain();
    write_reg(ffba_pkg::CFG_LIMIT, 21'd0);
    push_req(ffba_pkg::REQ_ALLOC, 20'd1000, 20'd0);
    push_req(ffba_pkg::REQ_ALLOC, 20'd0, 20'd0);
    drain();
    write_reg(ffba_pkg::CFG_HEADER, 21'd64);
    write_reg(ffba_pkg::CFG_LIMIT, 21'h1FFFFF);
    push_req(ffba_pkg::REQ_ALLOC, 20'd3, 20'd0);
    push_req(ffba_pkg::REQ_ALLOC, 20'hFFFFF, 20'd0);
    drain();

    for (int ph = 0; ph < 11; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 65; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 65; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      case (ph)
        1: write_reg(ffba_pkg::CFG_HEADER, 21'd25);
        2: write_reg(ffba_pkg::CFG_LIMIT, 21'd5000);
        3: write_reg(ffba_pkg::CFG_HEADER, 21'd1);
        4: write_reg(ffba_pkg::CFG_LIMIT, 21'd1048576);
        5: write_reg(ffba_pkg::CFG_HEADER, 21'd64);
        6: write_reg(ffba_pkg::CFG_LIMIT, 21'd0);
        7: write_reg(ffba_pkg::CFG_HEADER, 21'($urandom_range(1, 64)));
        8: write_reg(ffba_pkg::CFG_LIMIT, 21'($urandom_range(0, 1048576)));
        9: write_reg(ffba_pkg::CFG_HEADER, 21'd25);
        10: write_reg(ffba_pkg::CFG_LIMIT, 21'd1048575);
        default: ;
      endcase
      if (ph == 4) hold_cycles = 400;
      for (int b = 0; b < 3; b++) random_batch(50);
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS first_fit_block_allocator");
    end else begin
      $display("FAIL first_fit_block_allocator");
    end
    $finish;
  end
endmodule
